>>> rtl/tcw_pkg.sv
// Shared types, constants and controller/datapath link structs for the
// text console writer. No dependencies.
`default_nettype none

package tcw_pkg;

  localparam int COLUMNS_DEF   = 80;
  localparam int ROW_COUNT_DEF = 25;

  localparam int IDX_W  = 11;
  localparam int CELL_W = 16;
  localparam int CHAR_W = 8;

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [CELL_W-1:0] cell_t;
  typedef logic [IDX_W-1:0]  idx_t;

  localparam cell_t BLANK_CELL   = 16'h0700;
  localparam char_t NEWLINE_CODE = 8'd10;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef struct packed {
    logic capture;
    logic clear_wr;
    logic char_wr;
    logic read_cell;
    logic copy_rd;
    logic copy_wr;
    logic fill_wr;
    logic cnt_inc;
    logic cnt_zero;
    logic load_out;
  } tcw_cmd_t;

  typedef struct packed {
    logic op_read;
    logic in_range;
    logic scroll_needed;
    logic cnt_last;
    logic cnt_copy_last;
  } tcw_status_t;

endpackage

`default_nettype wire

>>> rtl/tcw_if.sv
// Valid/ready channel interfaces for console request and result transactions.
// Depends on tcw_pkg.
`default_nettype none

interface tcw_in_if import tcw_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  op;
  char_t char_code;
  char_t attribute;
  idx_t  cell_index;

  modport source (output valid, op, char_code, attribute, cell_index, input ready);
  modport sink   (input valid, op, char_code, attribute, cell_index, output ready);
endinterface

interface tcw_out_if import tcw_pkg::*; ();
  logic  valid;
  logic  ready;
  idx_t  cursor_pos;
  cell_t cell_value;
  logic  scrolled;

  modport source (output valid, cursor_pos, cell_value, scrolled, input ready);
  modport sink   (input valid, cursor_pos, cell_value, scrolled, output ready);
endinterface

`default_nettype wire

>>> rtl/tcw_ctrl.sv
// Sequencing state machine: clearing pass, item execution, scroll copy/fill
// and result handoff. Depends on tcw_pkg.
`default_nettype none

module tcw_ctrl import tcw_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  input  wire tcw_status_t status,
  output tcw_cmd_t         cmd
);

  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_EXEC    = 3'd2;
  localparam logic [2:0] ST_RD_WAIT = 3'd3;
  localparam logic [2:0] ST_COPY_RD = 3'd4;
  localparam logic [2:0] ST_COPY_WR = 3'd5;
  localparam logic [2:0] ST_FILL    = 3'd6;
  localparam logic [2:0] ST_DONE    = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next     = state;
    cmd            = '0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        cmd.cnt_inc  = 1'b1;
        if (status.cnt_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status.op_read) begin
          if (status.in_range) begin
            cmd.read_cell = 1'b1;
            state_next    = ST_RD_WAIT;
          end else begin
            state_next = ST_DONE;
          end
        end else begin
          cmd.char_wr = 1'b1;
          if (status.scroll_needed) begin
            cmd.cnt_zero = 1'b1;
            state_next   = ST_COPY_RD;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_RD_WAIT: state_next = ST_DONE;
      ST_COPY_RD: begin
        cmd.copy_rd = 1'b1;
        state_next  = ST_COPY_WR;
      end
      ST_COPY_WR: begin
        cmd.copy_wr = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_next  = status.cnt_copy_last ? ST_FILL : ST_COPY_RD;
      end
      ST_FILL: begin
        cmd.fill_wr = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (status.cnt_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/tcw_dpath.sv
// Datapath: screen memory, cursor registers, sweep counter, item capture and
// result register. Depends on tcw_pkg.
`default_nettype none

module tcw_dpath import tcw_pkg::*; #(
  parameter int COLUMNS   = COLUMNS_DEF,
  parameter int ROW_COUNT = ROW_COUNT_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire tcw_cmd_t cmd,
  output tcw_status_t   status,
  input  wire logic     in_op,
  input  wire char_t    in_char_code,
  input  wire char_t    in_attribute,
  input  wire idx_t     in_cell_index,
  output idx_t          cursor_pos,
  output cell_t         cell_value,
  output logic          scrolled
);

  localparam int TOTAL  = COLUMNS * ROW_COUNT;
  localparam int ADDR_W = $clog2(TOTAL);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROW_COUNT);
  localparam int CMP_W  = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TOTAL - 1);
  localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'(TOTAL - COLUMNS - 1);
  localparam logic [ADDR_W-1:0] BOTTOM    = ADDR_W'(TOTAL - COLUMNS);
  localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLUMNS);
  localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROW_COUNT - 1);

  cell_t mem [TOTAL];

  logic              op_q;
  char_t             char_q;
  char_t             attr_q;
  idx_t              idx_q;
  logic              scroll_q;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [ADDR_W-1:0] pos;
  logic [ADDR_W-1:0] cnt;
  cell_t             rdata;

  logic              newline;
  logic              wrap;
  logic              last_row;
  logic              in_range;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  cell_t             wdata;
  logic              re;
  logic [ADDR_W-1:0] raddr;

  assign newline  = (char_q == NEWLINE_CODE);
  assign wrap     = newline || (col == COL_LAST);
  assign last_row = (row == ROW_LAST);
  assign in_range = CMP_W'(idx_q) < CMP_W'(TOTAL);

  assign status.op_read       = (op_q == OP_READ);
  assign status.in_range      = in_range;
  assign status.scroll_needed = wrap && last_row;
  assign status.cnt_last      = (cnt == LAST_ADDR);
  assign status.cnt_copy_last = (cnt == COPY_LAST);

  always_comb begin
    we    = 1'b0;
    waddr = cnt;
    wdata = '0;
    if (cmd.clear_wr) begin
      we = 1'b1;
    end else if (cmd.char_wr && !newline) begin
      we    = 1'b1;
      waddr = pos;
      wdata = {attr_q, char_q};
    end else if (cmd.copy_wr) begin
      we    = 1'b1;
      wdata = rdata;
    end else if (cmd.fill_wr) begin
      we    = 1'b1;
      wdata = BLANK_CELL;
    end
  end

  assign re    = cmd.read_cell || cmd.copy_rd;
  assign raddr = cmd.read_cell ? ADDR_W'(idx_q) : cnt + COLS_A;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= in_op;
      char_q <= in_char_code;
      attr_q <= in_attribute;
      idx_q  <= in_cell_index;
    end
    if (cmd.load_out) begin
      cursor_pos <= IDX_W'(pos);
      cell_value <= (status.op_read && in_range) ? rdata : '0;
      scrolled   <= scroll_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      pos      <= '0;
      cnt      <= '0;
      scroll_q <= 1'b0;
    end else begin
      if (cmd.capture) scroll_q <= 1'b0;
      if (cmd.cnt_zero) begin
        cnt <= '0;
      end else if (cmd.cnt_inc) begin
        cnt <= cnt + 1'b1;
      end
      if (cmd.char_wr) begin
        scroll_q <= wrap && last_row;
        if (wrap) begin
          col <= '0;
          if (last_row) begin
            pos <= BOTTOM;
          end else begin
            row <= row + 1'b1;
            pos <= pos - ADDR_W'(col) + COLS_A;
          end
        end else begin
          col <= col + 1'b1;
          pos <= pos + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/text_console_writer.sv
// Text console writer: COLUMNS x ROW_COUNT cells of {attribute, character}. After reset the
// block runs a clearing pass over all COLUMNS*ROW_COUNT cells (2000 by default) with ready low.
// A read of a stored cell passes through an extra wait state for the memory read; a write that
// scrolls adds a copy that moves each cell below the top row up by one row, then a fill of the
// bottom row with blank cells, as the copy reads and writes each moved cell in separate states.
// One transaction is in flight at a time; a finished result waits in the output register.
// Depends on tcw_pkg, tcw_if, tcw_ctrl and tcw_dpath.
`default_nettype none

module text_console_writer import tcw_pkg::*; #(
  parameter int COLUMNS   = COLUMNS_DEF,
  parameter int ROW_COUNT = ROW_COUNT_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  tcw_in_if.sink    in_ch,
  tcw_out_if.source out_ch
);

  tcw_cmd_t    cmd;
  tcw_status_t status;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  tcw_dpath #(
    .COLUMNS   (COLUMNS),
    .ROW_COUNT (ROW_COUNT)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .in_op         (in_ch.op),
    .in_char_code  (in_ch.char_code),
    .in_attribute  (in_ch.attribute),
    .in_cell_index (in_ch.cell_index),
    .cursor_pos    (out_ch.cursor_pos),
    .cell_value    (out_ch.cell_value),
    .scrolled      (out_ch.scrolled)
  );

  localparam idx_t BOTTOM_POS = IDX_W'(COLUMNS * ROW_COUNT - COLUMNS);

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input accepted while a transaction is in flight");

  a_clear_pass: assert property (@(posedge clk)
    rst |=> !in_ch.ready)
    else $error("input ready during clearing pass");

  a_scroll_cursor: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.scrolled |-> out_ch.cursor_pos == BOTTOM_POS
                                        && out_ch.cell_value == '0)
    else $error("scroll result with cursor off the bottom row start");

endmodule

`default_nettype wire

>>> tb/console_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the text console writer: watches the request and result channels,
// keeps its own screen and cursor, and compares each result transaction in order.
// Depends on tcw_pkg and tcw_if.
module console_result_checker import tcw_pkg::*; #(
  parameter int COLUMNS   = COLUMNS_DEF,
  parameter int ROW_COUNT = ROW_COUNT_DEF
) (
  input  logic clk,
  input  logic rst,
  tcw_in_if    in_ch,
  tcw_out_if   out_ch,
  output int   mismatches,
  output int   results_awaited
);

  localparam int CELL_TOTAL = COLUMNS * ROW_COUNT;

  typedef struct packed {
    idx_t  cursor_pos;
    cell_t cell_value;
    logic  scrolled;
  } console_result_t;

  cell_t           screen_copy [CELL_TOTAL];
  int unsigned     col_now;
  int unsigned     row_now;
  console_result_t awaited_results [$];

  task automatic apply_request(input logic op, input char_t ch, input char_t attr,
                               input idx_t idx, output console_result_t res);
    int unsigned pos;
    logic        newline;
    res = '0;
    if (op == OP_READ) begin
      if (idx < CELL_TOTAL) res.cell_value = screen_copy[idx];
    end else begin
      newline = (ch == NEWLINE_CODE);
      if (!newline) begin
        pos = row_now * COLUMNS + col_now;
        screen_copy[pos] = {attr, ch};
        col_now++;
      end
      if (col_now >= COLUMNS || newline) begin
        col_now = 0;
        row_now++;
        if (row_now >= ROW_COUNT) begin
          for (int k = 0; k < CELL_TOTAL - COLUMNS; k++) screen_copy[k] = screen_copy[k + COLUMNS];
          for (int k = CELL_TOTAL - COLUMNS; k < CELL_TOTAL; k++) screen_copy[k] = BLANK_CELL;
          row_now = ROW_COUNT - 1;
          res.scrolled = 1'b1;
        end
      end
    end
    res.cursor_pos = idx_t'(row_now * COLUMNS + col_now);
  endtask

  always @(posedge clk) begin
    console_result_t predicted;
    console_result_t seen;
    if (rst) begin
      for (int k = 0; k < CELL_TOTAL; k++) screen_copy[k] = '0;
      col_now = 0;
      row_now = 0;
      awaited_results.delete();
      mismatches <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        apply_request(in_ch.op, in_ch.char_code, in_ch.attribute, in_ch.cell_index, predicted);
        awaited_results.push_back(predicted);
      end
      if (out_ch.valid && out_ch.ready) begin
        seen.cursor_pos = out_ch.cursor_pos;
        seen.cell_value = out_ch.cell_value;
        seen.scrolled   = out_ch.scrolled;
        if (awaited_results.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result transaction: cursor_pos %0d cell_value %h scrolled %b",
                     $realtime, seen.cursor_pos, seen.cell_value, seen.scrolled);
          mismatches <= mismatches + 1;
        end else begin
          predicted = awaited_results.pop_front();
          if (seen.cursor_pos !== predicted.cursor_pos || seen.cell_value !== predicted.cell_value ||
              seen.scrolled !== predicted.scrolled) begin
            if (mismatches < 10)
              $display("%0t: mismatch: cursor_pos %0d/%0d cell_value %h/%h scrolled %b/%b (exp/act)",
                       $realtime, predicted.cursor_pos, seen.cursor_pos, predicted.cell_value,
                       seen.cell_value, predicted.scrolled, seen.scrolled);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
    results_awaited <= awaited_results.size();
  end

endmodule

>>> tb/text_console_writer_test.sv
`timescale 1ns / 100ps
// Top of the text console writer testbench: clock, reset, paced request stimulus and a
// stalling result receiver, with the checker beside the block and a stall watchdog.
// Depends on tcw_pkg, tcw_if, text_console_writer and console_result_checker.
module text_console_writer_test;
  import tcw_pkg::*;

  localparam int COLUMNS      = COLUMNS_DEF;
  localparam int ROW_COUNT    = ROW_COUNT_DEF;
  localparam int CELL_TOTAL   = COLUMNS * ROW_COUNT;
  localparam int ITEM_TARGET  = 1850;
  localparam int STALL_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_fire = 1'b0;
  int   idle_cycles = 0;
  int   items_sent = 0;
  int   burst_left = 0;
  int   rx_stretch_left = 0;
  int   rx_hold_left = 0;
  logic rx_choppy = 1'b0;
  int   mismatches;
  int   results_awaited;

  tcw_in_if  in_ch ();
  tcw_out_if out_ch ();

  text_console_writer #(.COLUMNS(COLUMNS), .ROW_COUNT(ROW_COUNT)) DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch)
  );

  console_result_checker #(.COLUMNS(COLUMNS), .ROW_COUNT(ROW_COUNT)) result_check (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .mismatches(mismatches), .results_awaited(results_awaited)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    in_fire  <= in_ch.valid && in_ch.ready;
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: free-running stretches alternate with choppy ones
  always @(negedge clk) begin
    if (rx_stretch_left == 0) begin
      rx_choppy       = !rx_choppy;
      rx_stretch_left = $urandom_range(100, 600);
      rx_hold_left    = 0;
    end
    rx_stretch_left--;
    if (!rx_choppy) begin
      out_ch.ready <= 1'b1;
    end else if (rx_hold_left == 0) begin
      rx_hold_left = $urandom_range(1, 20);
      out_ch.ready <= ($urandom_range(0, 1) == 1);
    end else begin
      rx_hold_left--;
    end
  end

  task automatic send_request(input logic op, input char_t ch, input char_t attr, input idx_t idx);
    if (burst_left == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
    end
    burst_left--;
    in_ch.op         = op;
    in_ch.char_code  = ch;
    in_ch.attribute  = attr;
    in_ch.cell_index = idx;
    in_ch.valid      = 1'b1;
    do @(negedge clk); while (!in_fire);
    items_sent++;
  endtask

  task automatic put_char(input char_t ch, input char_t attr);
    send_request(OP_WRITE, ch, attr, idx_t'($urandom_range(0, 2047)));
  endtask

  task automatic read_cell(input int idx);
    send_request(OP_READ, char_t'($urandom), char_t'($urandom), idx_t'(idx));
  endtask

  initial begin
    int    pick;
    int    seg_len;
    char_t seg_attr;
    char_t ch;
    in_ch.valid      = 1'b0;
    in_ch.op         = OP_WRITE;
    in_ch.char_code  = '0;
    in_ch.attribute  = '0;
    in_ch.cell_index = '0;
    out_ch.ready     = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: field extremes, newline, reads in and beyond the screen
    put_char(8'h00, 8'h00);
    put_char(8'hFF, 8'hFF);
    put_char(8'h55, 8'hAA);
    put_char(8'hAA, 8'h55);
    send_request(OP_WRITE, 8'h41, 8'h1F, idx_t'(2047));
    read_cell(0);
    read_cell(1);
    read_cell(4);
    read_cell(5);
    send_request(OP_WRITE, NEWLINE_CODE, 8'hFF, '0);
    read_cell(COLUMNS);
    put_char(8'h42, 8'h07);
    read_cell(COLUMNS);
    send_request(OP_WRITE, NEWLINE_CODE, 8'h00, idx_t'(2047));
    send_request(OP_WRITE, NEWLINE_CODE, 8'h3C, idx_t'(5));
    read_cell(CELL_TOTAL - 1);
    read_cell(CELL_TOTAL);
    read_cell(2047);
    read_cell(1024);
    read_cell(1023);
    send_request(OP_READ, NEWLINE_CODE, 8'hFF, idx_t'(3));

    // random: text lines that wrap and scroll, newline runs, read runs, noise
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 19);
      if (pick <= 8) begin
        seg_len  = $urandom_range(1, 100);
        seg_attr = char_t'($urandom);
        repeat (seg_len) begin
          if ($urandom_range(0, 29) == 0) ch = NEWLINE_CODE;
          else if ($urandom_range(0, 9) == 0) ch = char_t'($urandom);
          else ch = char_t'($urandom_range(32, 126));
          if ($urandom_range(0, 7) == 0) seg_attr = char_t'($urandom);
          put_char(ch, seg_attr);
        end
      end else if (pick <= 10) begin
        repeat ($urandom_range(1, 8)) put_char(NEWLINE_CODE, char_t'($urandom));
      end else if (pick <= 17) begin
        repeat ($urandom_range(1, 8)) begin
          case ($urandom_range(0, 7))
            6:       read_cell($urandom_range(CELL_TOTAL, 2047));
            7:       read_cell($urandom_range(CELL_TOTAL - COLUMNS, CELL_TOTAL - 1));
            default: read_cell($urandom_range(0, CELL_TOTAL - 1));
          endcase
        end
      end else begin
        send_request(logic'($urandom_range(0, 1)), char_t'($urandom), char_t'($urandom),
                     idx_t'($urandom_range(0, 2047)));
      end
    end

    in_ch.valid = 1'b0;
    while (results_awaited != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && results_awaited == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
